>>> hw/rtl/tpfs_pkg.sv
// ----------------------------------------------------------------------------
// tpfs_pkg
// Shared types and constants of the prefix-free word set checker.
// ----------------------------------------------------------------------------
package tpfs_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int ALPHABET_DEF   = 10;

    localparam int SYM_W    = 4;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 20;

    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SET_GOOD  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_WORD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             end_of_word;
        logic             end_of_set;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  word_index;
    } t_out_item;

endpackage

>>> hw/rtl/tpfs_node_mem.sv
// ----------------------------------------------------------------------------
// tpfs_node_mem
// Node pool memory: one row per trie node, one write and one read port,
// registered read data.
// ----------------------------------------------------------------------------
module tpfs_node_mem
    import tpfs_pkg::*;
#(
    parameter int DEPTH = NODE_COUNT_DEF,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/tpfs_out_reg.sv
// ----------------------------------------------------------------------------
// tpfs_out_reg
// Result output register: holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module tpfs_out_reg
    import tpfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    output logic      o_busy,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign n_valid = i_load | (r_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_busy      = r_valid & i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

>>> hw/rtl/trie_prefix_free_set_check_unit.sv
// ----------------------------------------------------------------------------
// trie_prefix_free_set_check_unit
// Prefix-free word set checker: walks each word down a trie kept in a node
// pool memory, flags prefixes and duplicates, answers once per word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall   | symbol, end_of_word, end_of_set
//  out     | output    | o_out_valid / i_out_stall | status, word_index
//
//  A symbol is taken in S_IDLE, which reads the current node's row, and is
//  applied in S_WALK, which updates it; this read-then-use of the node memory
//  sets the rate. A word-ending symbol then goes to S_CHECK (read and mark
//  the final node) and S_DONE (the result), straight to S_DONE when the walk
//  meets a word end or an empty pool, or from S_IDLE when the word is known
//  bad or latched. After reset a clearing pass writes every node row with
//  o_in_stall high. A result stays in the output register while stalled;
//  the next item is taken meanwhile, and the block holds only when a second
//  result is ready before the first has gone.
// ----------------------------------------------------------------------------
module trie_prefix_free_set_check_unit
    import tpfs_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ALPHABET   = ALPHABET_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int CH_W  = ALPHABET * NW;
    localparam int ROW_W = CH_W + 1;

    localparam logic [NW:0]   POOL_END = (NW+1)'(NODE_COUNT);
    localparam logic [NW-1:0] CLR_LAST = NW'(NODE_COUNT - 1);
    localparam logic [SYM_W-1:0] SYM_TOP = SYM_W'(ALPHABET - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [NW-1:0]    r_clr_addr, n_clr_addr;
    logic [NW-1:0]    r_cur, n_cur;
    logic [NW:0]      r_free, n_free;
    logic             r_conflict, n_conflict;
    logic             r_short, n_short;
    logic             r_latched, n_latched;
    logic [INDEX_W-1:0] r_count, n_count;
    logic [SYM_W-1:0] r_sym, n_sym;
    logic             r_eow, n_eow;
    logic             r_eos, n_eos;

    logic             wr_en;
    logic [NW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_data;
    logic [NW-1:0]    rd_addr;
    logic [ROW_W-1:0] rd_data;

    logic             in_take;
    logic             row_end;
    logic             row_has_child;
    logic [NW-1:0]    child;
    logic             child_none;
    logic             pool_full;
    logic [NW-1:0]    next_node;
    logic [ROW_W-1:0] row_linked;
    logic [SYM_W-1:0] sym_clamped;

    logic             out_load;
    logic             out_busy;
    t_out_item        out_item;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_take    = i_in_valid & ~o_in_stall;

    // letters beyond the alphabet fold onto the last letter
    assign sym_clamped = (32'(i_in_item.symbol) >= ALPHABET) ? SYM_TOP : i_in_item.symbol;

    assign row_end       = rd_data[ROW_W-1];
    assign row_has_child = |rd_data[CH_W-1:0];
    assign child         = rd_data[r_sym*NW +: NW];
    assign child_none    = (child == '0);
    assign pool_full     = (r_free >= POOL_END);
    assign next_node     = child_none ? r_free[NW-1:0] : child;

    always_comb begin
        row_linked = rd_data;
        row_linked[r_sym*NW +: NW] = r_free[NW-1:0];
    end

    // result of the word just ended, the first fault met along it decides
    always_comb begin
        out_item.word_index = r_count;
        priority if (r_latched) begin
            out_item.status = ST_IGNORED;
        end else if (r_short) begin
            out_item.status = ST_POOL_FULL;
        end else if (r_conflict) begin
            out_item.status = ST_BAD_WORD;
        end else if (r_eos) begin
            out_item.status = ST_SET_GOOD;
        end else begin
            out_item.status = ST_ACCEPT;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cur      = r_cur;
        n_free     = r_free;
        n_conflict = r_conflict;
        n_short    = r_short;
        n_latched  = r_latched;
        n_count    = r_count;
        n_sym      = r_sym;
        n_eow      = r_eow;
        n_eos      = r_eos;
        wr_en      = 1'b0;
        wr_addr    = r_cur;
        wr_data    = row_linked;
        rd_addr    = r_cur;
        out_load   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
                n_clr_addr = r_clr_addr + NW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    n_sym = sym_clamped;
                    n_eow = i_in_item.end_of_word;
                    n_eos = i_in_item.end_of_set;
                    if (!r_latched && !r_conflict && !r_short) begin
                        n_state = S_WALK;
                    end else if (i_in_item.end_of_word) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                rd_addr = next_node;
                if (row_end) begin
                    n_conflict = 1'b1;
                end else if (child_none && pool_full) begin
                    n_short = 1'b1;
                end else begin
                    n_cur = next_node;
                    if (child_none) begin
                        wr_en  = 1'b1;
                        n_free = r_free + (NW+1)'(1);
                    end
                end
                if (!r_eow) begin
                    n_state = S_IDLE;
                end else if (row_end || (child_none && pool_full)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // final node must be neither a word end nor an inner node
                if (row_end || row_has_child) begin
                    n_conflict = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data | {1'b1, {CH_W{1'b0}}};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!out_busy) begin
                    out_load   = 1'b1;
                    n_latched  = r_latched | (out_item.status != ST_ACCEPT);
                    n_count    = (r_count == INDEX_MAX) ? r_count : r_count + INDEX_W'(1);
                    n_cur      = '0;
                    n_conflict = 1'b0;
                    n_short    = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_cur      <= '0;
            r_free     <= (NW+1)'(1);
            r_conflict <= 1'b0;
            r_short    <= 1'b0;
            r_latched  <= 1'b0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cur      <= n_cur;
            r_free     <= n_free;
            r_conflict <= n_conflict;
            r_short    <= n_short;
            r_latched  <= n_latched;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        r_eow <= n_eow;
        r_eos <= n_eos;
    end

    tpfs_node_mem #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ROW_W),
        .AW    (NW)
    ) u_node_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tpfs_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_item      (out_item),
        .o_busy      (out_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
